// ===== design/assert_macros.svh =====
// Shared assertion macros for the block median filter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high
`define BMF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset
`define BMF_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bmf_pkg.sv =====
package bmf_pkg;

   // Per-cell insertion control, driven by the fill counter
   typedef struct packed {
      logic insert;    // a word is being inserted this cycle
      logic occupied;  // cell holds a sample of the current block
      logic at_tail;   // cell is the first free slot of the block
   } cell_ctrl_type;

endpackage

// ===== design/bmf_cell.sv =====
module bmf_cell
   import bmf_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   prev_gt,
   input  logic [SAMPLE_BITS-1:0] prev_value,
   output logic                   gt,
   output logic [SAMPLE_BITS-1:0] value,
   output logic [SAMPLE_BITS-1:0] value_next
);

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;

   // Compare own sample against the incoming word
   assign gt = ctrl.occupied && (value_ff > sample);

   // Shift from the left neighbor, take the new word, or hold
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (prev_gt) begin
            value_in = prev_value;
         end else if (gt || ctrl.at_tail) begin
            value_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign value_next = value_in;

endmodule

// ===== design/bmf_mid_avg.sv =====
module bmf_mid_avg
   import bmf_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [SAMPLE_BITS-1:0] lo,
   input  logic [SAMPLE_BITS-1:0] hi,
   output logic                   load_ok,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_median
);

`include "assert_macros.svh"

   logic                   pair_valid_ff;
   logic                   pair_valid_in;
   logic [SAMPLE_BITS-1:0] lo_ff;
   logic [SAMPLE_BITS-1:0] hi_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [SAMPLE_BITS-1:0] median_ff;
   logic [SAMPLE_BITS:0]   pair_sum;
   logic                   out_free;
   logic                   pair_adv;

   // Output register is free when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pair_adv = pair_valid_ff && out_free;
   assign load_ok  = !pair_valid_ff || out_free;

   // Floor of the mean of the middle pair
   assign pair_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   assign pair_valid_in = load || (pair_valid_ff && !out_free);
   assign rsp_valid_in  = pair_adv || (rsp_valid_ff && !rsp_ready);

   // Hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pair_valid_ff <= pair_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture the pair and advance the result word
   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff <= lo;
         hi_ff <= hi;
      end
      if (pair_adv) begin
         median_ff <= pair_sum[SAMPLE_BITS:1];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = median_ff;

   `BMF_ASSERT(a_load_has_room, clock, reset, load |-> load_ok, "pair loaded while stage is full")
   `BMF_ASSERT(a_pair_held, clock, reset, (pair_valid_ff && !out_free) |=> (pair_valid_ff && $stable(lo_ff) && $stable(hi_ff)), "stalled middle pair lost")
   `BMF_ASSERT_NR(a_reset_clears, clock, reset |=> (!pair_valid_ff && !rsp_valid_ff), "reset did not clear flags")

endmodule

// ===== design/block_median_filter_core.sv =====
// Block median filter: sorts each block of BLOCK_LEN words in a chain of insertion cells.
// Throughput: one sample word per cycle while req_ready is high, set by the compare-and-shift of each cell.
// Result path: the middle pair is captured at the edge that accepts the last sample of a block,
// then the add and halve feed the result word register, unless a held result word stalls it.
// req_ready drops only while a captured pair waits behind a stalled result word.
// Synchronous reset empties the block and clears result flags; cell contents are not cleared.
module block_median_filter_core
   import bmf_pkg::*;
#(
   parameter int BLOCK_LEN   = 20,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_median
);

`include "assert_macros.svh"

   localparam int CNT_W   = $clog2(BLOCK_LEN);
   localparam int RANK_LO = (BLOCK_LEN - 1) / 2;
   localparam int RANK_HI = BLOCK_LEN / 2;
   localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(BLOCK_LEN - 1);

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   accept;
   logic                   block_done;
   logic                   load_ok;
   cell_ctrl_type          ctrl [BLOCK_LEN];
   logic                   cell_gt [BLOCK_LEN];
   logic [SAMPLE_BITS-1:0] cell_value [BLOCK_LEN];
   logic [SAMPLE_BITS-1:0] cell_next [BLOCK_LEN];

   assign req_ready  = load_ok;
   assign accept     = req_valid && req_ready;
   assign block_done = accept && (count_ff == LAST_SLOT);

   // Advance the fill count; wrap when the block completes
   always_comb begin
      count_in = count_ff;
      if (block_done) begin
         count_in = '0;
      end else if (accept) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Insertion chain
   for (genvar i = 0; i < BLOCK_LEN; i++) begin : g_cell
      assign ctrl[i].insert   = accept;
      assign ctrl[i].occupied = (CNT_W'(i) < count_ff);
      assign ctrl[i].at_tail  = (CNT_W'(i) == count_ff);

      if (i == 0) begin : g_head
         bmf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clock      (clock),
            .ctrl       (ctrl[i]),
            .sample     (req_sample),
            .prev_gt    (1'b0),
            .prev_value (req_sample),
            .gt         (cell_gt[i]),
            .value      (cell_value[i]),
            .value_next (cell_next[i])
         );
      end else begin : g_body
         bmf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clock      (clock),
            .ctrl       (ctrl[i]),
            .sample     (req_sample),
            .prev_gt    (cell_gt[i-1]),
            .prev_value (cell_value[i-1]),
            .gt         (cell_gt[i]),
            .value      (cell_value[i]),
            .value_next (cell_next[i])
         );
      end
   end

   // Capture the middle pair on the last word and average it
   bmf_mid_avg #(.SAMPLE_BITS(SAMPLE_BITS)) u_mid_avg (
      .clock      (clock),
      .reset      (reset),
      .load       (block_done),
      .lo         (cell_next[RANK_LO]),
      .hi         (cell_next[RANK_HI]),
      .load_ok    (load_ok),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_median (rsp_median)
   );

   `BMF_ASSERT(a_wrap, clock, reset, block_done |=> (count_ff == '0), "fill count did not wrap")
   `BMF_ASSERT(a_step, clock, reset, (accept && !block_done) |=> (count_ff == $past(count_ff) + CNT_W'(1)), "fill count missed a word")
   `BMF_ASSERT(a_sorted, clock, reset, (count_ff > CNT_W'(1)) |-> (cell_value[0] <= cell_value[1]), "chain head out of order")
   `BMF_ASSERT_NR(a_count_range, clock, !reset |-> (count_ff <= LAST_SLOT), "fill count past block end")

endmodule
